@@ hw/rtl/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   localparam int KEYWORD_PREFIX_LEN = 5;
   // longest keyword, in bytes
   localparam int KW_MAX_LEN = 5;
   // result queue words
   localparam int QUEUE_DEPTH = 4;

   localparam logic REC_TEXT  = 1'b0;
   localparam logic REC_TOKEN = 1'b1;

   localparam logic [5:0] TK_EOF     = 6'd0;
   localparam logic [5:0] TK_SEMI    = 6'd1;
   localparam logic [5:0] TK_LPAREN  = 6'd2;
   localparam logic [5:0] TK_RPAREN  = 6'd3;
   localparam logic [5:0] TK_CHAR    = 6'd4;
   localparam logic [5:0] TK_STR     = 6'd5;
   localparam logic [5:0] TK_NAME    = 6'd6;
   localparam logic [5:0] TK_LET     = 6'd7;
   localparam logic [5:0] TK_IN      = 6'd8;
   localparam logic [5:0] TK_IF      = 6'd9;
   localparam logic [5:0] TK_CONS    = 6'd10;
   localparam logic [5:0] TK_HD      = 6'd11;
   localparam logic [5:0] TK_TL      = 6'd12;
   localparam logic [5:0] TK_NIL     = 6'd13;
   localparam logic [5:0] TK_NULL    = 6'd14;
   localparam logic [5:0] TK_CHR     = 6'd15;
   localparam logic [5:0] TK_TRUE    = 6'd16;
   localparam logic [5:0] TK_FALSE   = 6'd17;
   localparam logic [5:0] TK_NUM     = 6'd18;
   localparam logic [5:0] TK_PUNCT   = 6'd19;
   localparam logic [5:0] TK_AND     = 6'd20;
   localparam logic [5:0] TK_OR      = 6'd21;
   localparam logic [5:0] TK_LT      = 6'd22;
   localparam logic [5:0] TK_GT      = 6'd23;
   localparam logic [5:0] TK_ASSIGN  = 6'd24;
   localparam logic [5:0] TK_PLUS    = 6'd25;
   localparam logic [5:0] TK_MINUS   = 6'd26;
   localparam logic [5:0] TK_STAR    = 6'd27;
   localparam logic [5:0] TK_SLASH   = 6'd28;
   localparam logic [5:0] TK_PERCENT = 6'd29;
   localparam logic [5:0] TK_BANG    = 6'd30;
   localparam logic [5:0] TK_LE      = 6'd31;
   localparam logic [5:0] TK_GE      = 6'd32;
   localparam logic [5:0] TK_NE      = 6'd33;
   localparam logic [5:0] TK_EQ      = 6'd34;
   localparam logic [5:0] TK_ERROR   = 6'd35;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [7:0]  text_byte;
      logic [5:0]  token_kind;
      logic [31:0] token_value;
      logic        last;
   } rsp_type;

   // words produced by one input byte, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_type;

   function automatic rsp_type token_rec(input logic [5:0] kind, input logic [31:0] value);
      rsp_type r;
      r.record_kind = REC_TOKEN;
      r.text_byte   = 8'd0;
      r.token_kind  = kind;
      r.token_value = value;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic rsp_type text_rec(input logic [7:0] c);
      rsp_type r;
      r.record_kind = REC_TEXT;
      r.text_byte   = c;
      r.token_kind  = TK_EOF;
      r.token_value = 32'd0;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // text holds the first bytes of the name, first byte lowest, zero padded
   function automatic logic [5:0] keyword_kind(input logic [39:0] text,
                                               input logic [2:0] len);
      logic [5:0] kind;
      kind = TK_NAME;
      if (len == 3'd3 && text == 40'h000074656C) kind = TK_LET;
      if (len == 3'd2 && text == 40'h0000006E69) kind = TK_IN;
      if (len == 3'd2 && text == 40'h0000006669) kind = TK_IF;
      if (len == 3'd4 && text == 40'h00736E6F63) kind = TK_CONS;
      if (len == 3'd2 && text == 40'h0000006468) kind = TK_HD;
      if (len == 3'd2 && text == 40'h0000006C74) kind = TK_TL;
      if (len == 3'd3 && text == 40'h00006C696E) kind = TK_NIL;
      if (len == 3'd4 && text == 40'h006C6C756E) kind = TK_NULL;
      if (len == 3'd3 && text == 40'h0000726863) kind = TK_CHR;
      if (len == 3'd4 && text == 40'h0065757274) kind = TK_TRUE;
      if (len == 3'd5 && text == 40'h65736C6166) kind = TK_FALSE;
      return kind;
   endfunction

   function automatic logic [5:0] op_kind(input logic [15:0] text, input logic [1:0] len);
      logic [5:0] kind;
      kind = TK_PUNCT;
      if (len == 2'd1) begin
         unique case (text[7:0])
            "&":     kind = TK_AND;
            "|":     kind = TK_OR;
            "<":     kind = TK_LT;
            ">":     kind = TK_GT;
            "=":     kind = TK_ASSIGN;
            "+":     kind = TK_PLUS;
            "-":     kind = TK_MINUS;
            "*":     kind = TK_STAR;
            "/":     kind = TK_SLASH;
            "%":     kind = TK_PERCENT;
            "!":     kind = TK_BANG;
            default: kind = TK_PUNCT;
         endcase
      end else if (len == 2'd2) begin
         if (text == {8'h3D, 8'h3C}) kind = TK_LE;
         if (text == {8'h3D, 8'h3E}) kind = TK_GE;
         if (text == {8'h3D, 8'h21}) kind = TK_NE;
         if (text == {8'h3D, 8'h3D}) kind = TK_EQ;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stt_lex.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_lex #(
   parameter int KEYWORD_PREFIX_LEN = stt_pkg::KEYWORD_PREFIX_LEN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire stt_pkg::req_type  req_data,
   output stt_pkg::step_type      step
);

   localparam int PREFIX_W = 8 * KEYWORD_PREFIX_LEN;
   localparam int NLEN_W   = $clog2(KEYWORD_PREFIX_LEN + 2);

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_COMMENT = 3'd1;
   localparam logic [2:0] M_CHAR1   = 3'd2;
   localparam logic [2:0] M_CHAR2   = 3'd3;
   localparam logic [2:0] M_STR     = 3'd4;
   localparam logic [2:0] M_NAME    = 3'd5;
   localparam logic [2:0] M_NUM     = 3'd6;
   localparam logic [2:0] M_OP      = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   logic [2:0]          mode_ff, mode_in;
   logic [PREFIX_W-1:0] name_prefix_ff, name_prefix_in;
   logic [NLEN_W-1:0]   name_len_ff, name_len_in;
   logic [31:0]         acc_ff, acc_in;
   logic [15:0]         op_prefix_ff, op_prefix_in;
   logic [1:0]          op_len_ff, op_len_in;
   logic [7:0]          chr_ff, chr_in;

   logic [7:0]        c;
   logic              eoi;
   logic              head_have, idle_have, eof_have, run_idle;
   stt_pkg::rsp_type  head_rec, idle_rec, eof_rec, first_rec, second_rec;
   logic              name_cont, op_cont;
   logic [2:0]        kw_len;
   logic [1:0]        rec_count;

   assign c   = req_data.in_byte;
   assign eoi = req_data.end_of_input;

   assign name_cont = stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == CH_UNDER ||
                      c == CH_QUOTE;
   assign op_cont   = c != CH_NUL && !stt_pkg::is_alpha(c) && !stt_pkg::is_digit(c) &&
                      c != CH_SEMI && c != CH_LP && c != CH_RP && c != CH_SPACE &&
                      c != CH_TAB && c != CH_LF && c != CH_HASH;

   // any name longer than the longest keyword can never match
   assign kw_len = (name_len_ff > NLEN_W'(stt_pkg::KW_MAX_LEN)) ? 3'd7 : 3'(name_len_ff);

   assign eof_rec = stt_pkg::token_rec(stt_pkg::TK_EOF, 32'd0);

   always_comb begin
      mode_in        = mode_ff;
      name_prefix_in = name_prefix_ff;
      name_len_in    = name_len_ff;
      acc_in         = acc_ff;
      op_prefix_in   = op_prefix_ff;
      op_len_in      = op_len_ff;
      chr_in         = chr_ff;
      head_have      = 1'b0;
      head_rec       = stt_pkg::text_rec(c);
      idle_have      = 1'b0;
      idle_rec       = stt_pkg::text_rec(c);
      run_idle       = 1'b0;

      unique case (mode_ff)
         M_COMMENT: begin
            if (eoi || c == CH_LF) mode_in = M_IDLE;
         end
         M_CHAR1: begin
            if (eoi) begin
               head_have = 1'b1;
               head_rec  = stt_pkg::token_rec(stt_pkg::TK_ERROR, 32'd0);
               mode_in   = M_IDLE;
            end else begin
               chr_in  = c;
               mode_in = M_CHAR2;
            end
         end
         M_CHAR2: begin
            head_have = 1'b1;
            head_rec  = (!eoi && c == CH_QUOTE) ?
                        stt_pkg::token_rec(stt_pkg::TK_CHAR, {24'd0, chr_ff}) :
                        stt_pkg::token_rec(stt_pkg::TK_ERROR, 32'd0);
            mode_in   = M_IDLE;
         end
         M_STR: begin
            head_have = 1'b1;
            if (eoi || c == CH_DQ) begin
               head_rec = stt_pkg::token_rec(stt_pkg::TK_STR, 32'd0);
               mode_in  = M_IDLE;
            end
         end
         M_NAME: begin
            head_have = 1'b1;
            if (!eoi && name_cont) begin
               if (name_len_ff < NLEN_W'(KEYWORD_PREFIX_LEN))
                  name_prefix_in[8*name_len_ff +: 8] = c;
               if (name_len_ff < NLEN_W'(KEYWORD_PREFIX_LEN + 1))
                  name_len_in = name_len_ff + NLEN_W'(1);
            end else begin
               head_rec = stt_pkg::token_rec(
                  stt_pkg::keyword_kind(name_prefix_ff[8*stt_pkg::KW_MAX_LEN-1:0], kw_len),
                  32'd0);
               mode_in  = M_IDLE;
               run_idle = !eoi;
            end
         end
         M_NUM: begin
            if (!eoi && stt_pkg::is_digit(c)) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + {24'd0, c - CH_ZERO};
            end else begin
               head_have = 1'b1;
               head_rec  = stt_pkg::token_rec(stt_pkg::TK_NUM, acc_ff);
               mode_in   = M_IDLE;
               run_idle  = !eoi;
            end
         end
         M_OP: begin
            head_have = 1'b1;
            if (!eoi && op_cont) begin
               if (op_len_ff == 2'd0) op_prefix_in[7:0] = c;
               if (op_len_ff == 2'd1) op_prefix_in[15:8] = c;
               if (op_len_ff != 2'd3) op_len_in = op_len_ff + 2'd1;
            end else begin
               head_rec = stt_pkg::token_rec(stt_pkg::op_kind(op_prefix_ff, op_len_ff),
                                             32'd0);
               mode_in  = M_IDLE;
               run_idle = !eoi;
            end
         end
         default: begin
            run_idle = !eoi;
         end
      endcase

      // byte seen between tokens, also the byte that closed a name, number or run
      if (run_idle) begin
         mode_in = M_IDLE;
         priority if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         end else if (c == CH_HASH) begin
            mode_in = M_COMMENT;
         end else if (c == CH_SEMI) begin
            idle_have = 1'b1;
            idle_rec  = stt_pkg::token_rec(stt_pkg::TK_SEMI, 32'd0);
         end else if (c == CH_LP) begin
            idle_have = 1'b1;
            idle_rec  = stt_pkg::token_rec(stt_pkg::TK_LPAREN, 32'd0);
         end else if (c == CH_RP) begin
            idle_have = 1'b1;
            idle_rec  = stt_pkg::token_rec(stt_pkg::TK_RPAREN, 32'd0);
         end else if (c == CH_QUOTE) begin
            mode_in = M_CHAR1;
         end else if (c == CH_DQ) begin
            mode_in = M_STR;
         end else if (c == CH_NUL) begin
            idle_have = 1'b1;
            idle_rec  = stt_pkg::token_rec(stt_pkg::TK_PUNCT, 32'd0);
         end else if (stt_pkg::is_alpha(c)) begin
            name_prefix_in = PREFIX_W'(c);
            name_len_in    = NLEN_W'(1);
            mode_in        = M_NAME;
            idle_have      = 1'b1;
         end else if (stt_pkg::is_digit(c)) begin
            acc_in  = {24'd0, c - CH_ZERO};
            mode_in = M_NUM;
         end else begin
            op_prefix_in = {8'd0, c};
            op_len_in    = 2'd1;
            mode_in      = M_OP;
            idle_have    = 1'b1;
         end
      end

      eof_have = eoi && mode_in == M_IDLE;
   end

   // idle and eof words never come from the same byte
   always_comb begin
      rec_count  = 2'(head_have) + 2'(idle_have) + 2'(eof_have);
      first_rec  = head_have ? head_rec : (idle_have ? idle_rec : eof_rec);
      second_rec = (head_have && idle_have) ? idle_rec : eof_rec;
      first_rec.last  = rec_count == 2'd1;
      second_rec.last = 1'b1;
      step.count  = rec_count;
      step.first  = first_rec;
      step.second = second_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_IDLE;
         name_prefix_ff <= '0;
         name_len_ff    <= '0;
         acc_ff         <= '0;
         op_prefix_ff   <= '0;
         op_len_ff      <= '0;
         chr_ff         <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         name_prefix_ff <= name_prefix_in;
         name_len_ff    <= name_len_in;
         acc_ff         <= acc_in;
         op_prefix_ff   <= op_prefix_in;
         op_len_ff      <= op_len_in;
         chr_ff         <= chr_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Source text tokenizer.
// req channel: one word per source byte (in_byte), or an end-of-input mark.
// rsp channel: a stream of words, each a text byte of a name, string or
//   operator run, or a token-complete word with kind and value; last marks
//   the final word caused by one req word (a byte may cause none, one or two).
// Both channels: a word moves on a clock edge with valid high and stall low.
// The words caused by a byte are written into the result queue when the byte is accepted.
// Throughput: one byte per cycle while bytes give at most one word each and
//   rsp is not stalled; the rsp side drains one word per cycle from a
//   four-word queue, and req_stall is raised while the queue holds more than
//   two words, so bytes giving two words each fill the queue until req_stall rises.
// A stalled rsp holds its word; the queue absorbs it until req_stall rises.
// Reset (synchronous) empties the queue and returns the lexer to the state
//   between tokens with all prefixes and the number cleared. No other
//   start-up time.

module source_text_tokenizer #(
   parameter int KEYWORD_PREFIX_LEN = stt_pkg::KEYWORD_PREFIX_LEN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stt_pkg::rsp_type       rsp_data
);

   localparam int PTR_W = $clog2(stt_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(stt_pkg::QUEUE_DEPTH + 1);

   stt_pkg::step_type step;
   stt_pkg::rsp_type  queue_ff [stt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;
   logic [1:0]        push_n;

   stt_lex #(
      .KEYWORD_PREFIX_LEN(KEYWORD_PREFIX_LEN)
   ) u_lex (
      .clock   (clock),
      .reset   (reset),
      .step_en (push),
      .req_data(req_data),
      .step    (step)
   );

   // room for two words must be there before a byte is taken
   assign req_stall = count_ff > CNT_W'(stt_pkg::QUEUE_DEPTH - 2);
   assign push      = req_valid && !req_stall;
   assign push_n    = push ? step.count : 2'd0;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push && step.count != 2'd0) queue_ff[wr_ptr_ff] <= step.first;
      if (push && step.count == 2'd2) queue_ff[wr_ptr_ff + PTR_W'(1)] <= step.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(stt_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_eoi_emits: assert property (@(posedge clock) disable iff (reset)
      (push && req_data.end_of_input) |-> step.count != 2'd0)
      else $error("end of input produced no token");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count lost track on pop");
`endif

endmodule

`default_nettype wire

@@ test/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps

module source_text_tokenizer_test;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int TOTAL_BYTES  = 800;
   localparam int IDLE_PERCENT = 18;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 10;

   typedef enum logic [3:0] {
      LX_IDLE, LX_COMMENT, LX_QUOTE_OPEN, LX_QUOTE_CLOSE,
      LX_STRING, LX_NAME, LX_NUMBER, LX_OPERATOR
   } lex_mode_type;

   typedef struct packed {
      stt_pkg::req_type word;
      logic             hold;    // wait for all expected words before sending
   } source_item_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   stt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   stt_pkg::rsp_type rsp_data;

   source_item_type  source_bytes[$];
   stt_pkg::rsp_type expected_words[$];
   stt_pkg::rsp_type step_words[$];

   // lexer shadow state
   lex_mode_type lx_mode = LX_IDLE;
   logic [39:0]  name_msb = '0;     // first name bytes, first byte highest
   logic [2:0]   name_len = '0;
   logic [31:0]  num_value = '0;
   logic [15:0]  op_msb = '0;       // first two run bytes, first byte highest
   logic [1:0]   op_len = '0;
   logic [7:0]   quoted_char = '0;

   int  bytes_sent = 0;
   int  idle_cycles = 0;
   bit  failed = 1'b0;
   bit  hold_next = 1'b0;
   logic calm;

   source_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no idling on either side for a while in the middle
   assign calm = bytes_sent >= 300 && bytes_sent < 450;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   function automatic bit in_operator(logic [7:0] c);
      return c != CH_NUL && !is_letter(c) && !is_numeral(c) && !is_blank(c)
         && c != CH_SEMI && c != CH_LPAREN && c != CH_RPAREN && c != CH_HASH;
   endfunction

   function automatic void put_token(logic [5:0] kind, logic [31:0] value);
      stt_pkg::rsp_type w;
      w = '0;
      w.record_kind = stt_pkg::REC_TOKEN;
      w.token_kind  = kind;
      w.token_value = value;
      step_words.push_back(w);
   endfunction

   function automatic void put_text(logic [7:0] c);
      stt_pkg::rsp_type w;
      w = '0;
      w.record_kind = stt_pkg::REC_TEXT;
      w.text_byte   = c;
      step_words.push_back(w);
   endfunction

   function automatic bit name_is(logic [39:0] spelling, int n);
      return name_len == n && name_msb == spelling;
   endfunction

   function automatic logic [5:0] name_token();
      if (name_is("let", 3))   return stt_pkg::TK_LET;
      if (name_is("in", 2))    return stt_pkg::TK_IN;
      if (name_is("if", 2))    return stt_pkg::TK_IF;
      if (name_is("cons", 4))  return stt_pkg::TK_CONS;
      if (name_is("hd", 2))    return stt_pkg::TK_HD;
      if (name_is("tl", 2))    return stt_pkg::TK_TL;
      if (name_is("nil", 3))   return stt_pkg::TK_NIL;
      if (name_is("null", 4))  return stt_pkg::TK_NULL;
      if (name_is("chr", 3))   return stt_pkg::TK_CHR;
      if (name_is("true", 4))  return stt_pkg::TK_TRUE;
      if (name_is("false", 5)) return stt_pkg::TK_FALSE;
      return stt_pkg::TK_NAME;
   endfunction

   function automatic logic [5:0] op_token();
      if (op_len == 2'd1) begin
         case (op_msb[7:0])
            "&": return stt_pkg::TK_AND;
            "|": return stt_pkg::TK_OR;
            "<": return stt_pkg::TK_LT;
            ">": return stt_pkg::TK_GT;
            "=": return stt_pkg::TK_ASSIGN;
            "+": return stt_pkg::TK_PLUS;
            "-": return stt_pkg::TK_MINUS;
            "*": return stt_pkg::TK_STAR;
            "/": return stt_pkg::TK_SLASH;
            "%": return stt_pkg::TK_PERCENT;
            "!": return stt_pkg::TK_BANG;
            default: return stt_pkg::TK_PUNCT;
         endcase
      end
      if (op_len == 2'd2) begin
         if (op_msb == "<=") return stt_pkg::TK_LE;
         if (op_msb == ">=") return stt_pkg::TK_GE;
         if (op_msb == "!=") return stt_pkg::TK_NE;
         if (op_msb == "==") return stt_pkg::TK_EQ;
      end
      return stt_pkg::TK_PUNCT;
   endfunction

   function automatic void grow_name(logic [7:0] c);
      if (name_len < stt_pkg::KEYWORD_PREFIX_LEN) name_msb = {name_msb[31:0], c};
      if (name_len < stt_pkg::KEYWORD_PREFIX_LEN + 1) name_len = name_len + 3'd1;
      put_text(c);
   endfunction

   function automatic void grow_op(logic [7:0] c);
      if (op_len < 2'd2) op_msb = {op_msb[7:0], c};
      if (op_len < 2'd3) op_len = op_len + 2'd1;
      put_text(c);
   endfunction

   function automatic void start_token(logic [7:0] c);
      lx_mode = LX_IDLE;
      if (is_blank(c) || c == CH_CR) return;
      if (c == CH_HASH) lx_mode = LX_COMMENT;
      else if (c == CH_SEMI) put_token(stt_pkg::TK_SEMI, '0);
      else if (c == CH_LPAREN) put_token(stt_pkg::TK_LPAREN, '0);
      else if (c == CH_RPAREN) put_token(stt_pkg::TK_RPAREN, '0);
      else if (c == CH_QUOTE) lx_mode = LX_QUOTE_OPEN;
      else if (c == CH_DQUOTE) lx_mode = LX_STRING;
      else if (c == CH_NUL) put_token(stt_pkg::TK_PUNCT, '0);
      else if (is_letter(c)) begin
         name_msb = '0;
         name_len = '0;
         lx_mode = LX_NAME;
         grow_name(c);
      end else if (is_numeral(c)) begin
         num_value = 32'(c - 8'h30);
         lx_mode = LX_NUMBER;
      end else begin
         op_msb = '0;
         op_len = '0;
         lx_mode = LX_OPERATOR;
         grow_op(c);
      end
   endfunction

   // advance the shadow lexer by one accepted word, queue what it yields
   function automatic void lex_step(stt_pkg::req_type w);
      logic [7:0]       c;
      bit               eoi;
      stt_pkg::rsp_type tail;
      c = w.in_byte;
      eoi = w.end_of_input;
      step_words.delete();
      case (lx_mode)
         LX_COMMENT: begin
            if (eoi || c == CH_LF) lx_mode = LX_IDLE;
         end
         LX_QUOTE_OPEN: begin
            if (eoi) begin
               put_token(stt_pkg::TK_ERROR, '0);
               lx_mode = LX_IDLE;
            end else begin
               quoted_char = c;
               lx_mode = LX_QUOTE_CLOSE;
            end
         end
         LX_QUOTE_CLOSE: begin
            if (!eoi && c == CH_QUOTE) put_token(stt_pkg::TK_CHAR, {24'd0, quoted_char});
            else put_token(stt_pkg::TK_ERROR, '0);
            lx_mode = LX_IDLE;
         end
         LX_STRING: begin
            if (eoi || c == CH_DQUOTE) begin
               put_token(stt_pkg::TK_STR, '0);
               lx_mode = LX_IDLE;
            end else begin
               put_text(c);
            end
         end
         LX_NAME: begin
            if (!eoi && (is_letter(c) || is_numeral(c) || c == CH_UNDER || c == CH_QUOTE)) begin
               grow_name(c);
            end else begin
               put_token(name_token(), '0);
               lx_mode = LX_IDLE;
               if (!eoi) start_token(c);
            end
         end
         LX_NUMBER: begin
            if (!eoi && is_numeral(c)) begin
               num_value = num_value * 32'd10 + 32'(c - 8'h30);
            end else begin
               put_token(stt_pkg::TK_NUM, num_value);
               lx_mode = LX_IDLE;
               if (!eoi) start_token(c);
            end
         end
         LX_OPERATOR: begin
            if (!eoi && in_operator(c)) begin
               grow_op(c);
            end else begin
               put_token(op_token(), '0);
               lx_mode = LX_IDLE;
               if (!eoi) start_token(c);
            end
         end
         default: begin
            if (!eoi) start_token(c);
         end
      endcase
      if (eoi && lx_mode == LX_IDLE) put_token(stt_pkg::TK_EOF, '0);
      if (step_words.size() > 0) begin
         tail = step_words.pop_back();
         tail.last = 1'b1;
         step_words.push_back(tail);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   function automatic void add_byte(logic [7:0] c);
      source_item_type s;
      s.word.in_byte = c;
      s.word.end_of_input = 1'b0;
      s.hold = hold_next;
      hold_next = 1'b0;
      source_bytes.push_back(s);
   endfunction

   function automatic void add_end();
      source_item_type s;
      s.word.in_byte = 8'($urandom_range(255));
      s.word.end_of_input = 1'b1;
      s.hold = hold_next;
      hold_next = 1'b0;
      source_bytes.push_back(s);
   endfunction

   function automatic logic [7:0] random_op_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (!in_operator(c));
      return c;
   endfunction

   function automatic string keyword_text(int k);
      case (k)
         0: return "let";
         1: return "in";
         2: return "if";
         3: return "cons";
         4: return "hd";
         5: return "tl";
         6: return "nil";
         7: return "null";
         8: return "chr";
         9: return "true";
         default: return "false";
      endcase
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", field, want, got);
         failed = 1'b1;
      end
   endfunction

   initial begin
      logic [7:0] tok[$];
      string      s;
      string      singles;
      int         pick;
      int         n;
      bit         mid_hold_done;
      singles = "&|<>=+-*/%!";
      mid_hold_done = 1'b0;

      // directed corner cases
      add_end();
      add_byte(CH_NUL);
      add_byte(CH_QUOTE); add_byte(CH_NUL); add_byte(CH_QUOTE);
      add_byte(CH_QUOTE); add_byte("x"); add_byte("y");
      add_byte("<"); add_byte("="); add_byte(CH_NUL);
      add_byte(CH_CR);
      add_byte(8'hFF); add_end();
      add_byte(CH_HASH); add_byte(8'hFF); add_end();
      add_byte(CH_DQUOTE); add_byte(CH_NUL); add_end();
      add_byte(CH_QUOTE); add_end();
      add_byte(CH_QUOTE); add_byte("q"); add_end();
      add_byte("7"); add_end();

      hold_next = 1'b1;
      while (source_bytes.size() < TOTAL_BYTES) begin
         if (!mid_hold_done && source_bytes.size() >= TOTAL_BYTES / 2) begin
            hold_next = 1'b1;
            mid_hold_done = 1'b1;
         end
         tok.delete();
         pick = $urandom_range(99);
         if (pick < 15) begin
            s = keyword_text($urandom_range(10));
            n = $urandom_range(3);
            if (n == 0) s = {s, "s"};
            else if (n == 1) s = s.substr(0, s.len() - 2);
            for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
         end else if (pick < 30) begin
            tok.push_back($urandom_range(1) ? 8'($urandom_range("a", "z"))
                                             : 8'($urandom_range("A", "Z")));
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(4))
                  0: tok.push_back(8'($urandom_range("0", "9")));
                  1: tok.push_back($urandom_range(1) ? CH_UNDER : CH_QUOTE);
                  2: tok.push_back(8'($urandom_range("A", "Z")));
                  default: tok.push_back(8'($urandom_range("a", "z")));
               endcase
            end
         end else if (pick < 45) begin
            n = $urandom_range(9);
            if (n == 0) s = "4294967295";
            else if (n == 1) s = "4294967296";
            else s = "";
            for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
            if (n >= 2) begin
               n = (n == 9) ? $urandom_range(11, 14) : $urandom_range(1, 6);
               for (int i = 0; i < n; i++) tok.push_back(8'($urandom_range("0", "9")));
            end
         end else if (pick < 63) begin
            case ($urandom_range(2))
               0: tok.push_back(singles[$urandom_range(singles.len() - 1)]);
               1: begin
                  case ($urandom_range(3))
                     0: s = "<=";
                     1: s = ">=";
                     2: s = "!=";
                     default: s = "==";
                  endcase
                  tok.push_back(s[0]);
                  tok.push_back(s[1]);
               end
               default: begin
                  n = $urandom_range(1, 4);
                  for (int i = 0; i < n; i++) tok.push_back(random_op_char());
               end
            endcase
         end else if (pick < 71) begin
            tok.push_back(CH_DQUOTE);
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) begin
               tok.push_back(8'($urandom_range(255)));
               if (tok[$] == CH_DQUOTE) tok[$] = CH_NUL;
            end
            tok.push_back(CH_DQUOTE);
         end else if (pick < 78) begin
            tok.push_back(CH_QUOTE);
            tok.push_back(8'($urandom_range(255)));
            tok.push_back($urandom_range(7) != 0 ? CH_QUOTE : 8'($urandom_range(255)));
         end else if (pick < 85) begin
            case ($urandom_range(2))
               0: tok.push_back(CH_SEMI);
               1: tok.push_back(CH_LPAREN);
               default: tok.push_back(CH_RPAREN);
            endcase
         end else if (pick < 90) begin
            add_byte(CH_HASH);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) begin
               add_byte(8'($urandom_range(255)));
               if (source_bytes[$].word.in_byte == CH_LF) source_bytes[$].word.in_byte = CH_NUL;
            end
            add_byte(CH_LF);
         end else if (pick < 97) begin
            tok.push_back(8'($urandom_range(255)));
         end else begin
            add_end();
         end
         foreach (tok[i]) add_byte(tok[i]);
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(3))
               0: add_byte(CH_SPACE);
               1: add_byte(CH_TAB);
               2: add_byte(CH_LF);
               default: add_byte(CH_CR);
            endcase
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (source_bytes.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failed) begin
         $display("TB_ERROR");
      end else begin
         $display("TB_OK");
      end
      $finish;
   end

   // source side
   always @(posedge clock) begin : drive
      bit go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            lex_step(req_data);
            void'(source_bytes.pop_front());
            bytes_sent <= bytes_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            go = source_bytes.size() > 0
               && !(source_bytes[0].hold && expected_words.size() > 0)
               && (calm || $urandom_range(99) >= IDLE_PERCENT);
            if (go) req_data <= source_bytes[0].word;
            req_valid <= go;
         end
      end
   end

   // result side
   always @(posedge clock) begin : observe
      stt_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word %h", rsp_data);
               failed = 1'b1;
            end else begin
               want = expected_words.pop_front();
               check_field("record_kind", 32'(want.record_kind), 32'(rsp_data.record_kind));
               check_field("text_byte", 32'(want.text_byte), 32'(rsp_data.text_byte));
               check_field("token_kind", 32'(want.token_kind), 32'(rsp_data.token_kind));
               check_field("token_value", want.token_value, rsp_data.token_value);
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         rsp_stall <= !calm && $urandom_range(99) < IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
